/* rtl/core/ghbp_pkg.sv */
package ghbp_pkg;

   localparam int HISTORY_BITS_DEF  = 12;
   localparam int TABLE_ENTRIES_DEF = 4096;

   // Width of the history snapshot carried on the ports.
   localparam int HIST_OUT_BITS = 12;

   // Snapshot bits folded into the table index per cycle on a train.
   localparam int REDUCE_STEP = 4;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] CTR_MAX       = 2'd3;
   localparam logic [1:0] CTR_MIN       = 2'd0;
   localparam logic [1:0] CTR_TAKEN_MIN = 2'd2;

   typedef enum logic [1:0] {
      OP_PREDICT = 2'd0,
      OP_PUSH    = 2'd1,
      OP_TRAIN   = 2'd2
   } op_type;

   typedef enum logic {
      BK_CLEAR = 1'b0,
      BK_RUN   = 1'b1
   } back_state_type;

   typedef struct packed {
      logic [1:0]               op;
      logic                     outcome_taken;
      logic [HIST_OUT_BITS-1:0] saved_history;
   } req_type;

   typedef struct packed {
      logic                     predict_taken;
      logic [HIST_OUT_BITS-1:0] history_out;
   } rsp_type;

   // Work handed from the front to the back.
   typedef struct packed {
      logic                     is_train;
      logic                     outcome_taken;
      logic [HIST_OUT_BITS-1:0] history_out;
   } cmd_type;

   function automatic int ghbp_idx_bits(int entries);
      return $clog2(entries);
   endfunction

   function automatic int ghbp_snap_bits(int hist_bits);
      return (hist_bits < HIST_OUT_BITS) ? hist_bits : HIST_OUT_BITS;
   endfunction

   function automatic int ghbp_key_bits(int hist_bits, int entries);
      int ib;
      int sb;
      ib = ghbp_idx_bits(entries);
      sb = ghbp_snap_bits(hist_bits);
      return (ib > sb) ? ib : sb;
   endfunction

   // Snapshot maps to an index by truncation alone.
   function automatic bit ghbp_fast(int hist_bits, int entries);
      int sb;
      sb = ghbp_snap_bits(hist_bits);
      return ((entries & (entries - 1)) == 0) || (entries >= (1 << sb));
   endfunction

endpackage

/* rtl/core/ghbp_front.sv */
module ghbp_front #(
   parameter int HISTORY_BITS  = ghbp_pkg::HISTORY_BITS_DEF,
   parameter int TABLE_ENTRIES = ghbp_pkg::TABLE_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ghbp_pkg::req_type req_data,
   input  logic              clear_busy,
   output logic              enq_valid,
   input  logic              enq_ready,
   output ghbp_pkg::cmd_type enq_cmd,
   output logic [ghbp_pkg::ghbp_key_bits(HISTORY_BITS, TABLE_ENTRIES)-1:0] enq_key
);
   import ghbp_pkg::*;

   localparam int IdxBits  = ghbp_idx_bits(TABLE_ENTRIES);
   localparam int SnapBits = ghbp_snap_bits(HISTORY_BITS);
   localparam int KeyBits  = ghbp_key_bits(HISTORY_BITS, TABLE_ENTRIES);
   localparam int HistWrap = (1 << HISTORY_BITS) % TABLE_ENTRIES;
   localparam logic [IdxBits:0] TabSize  = (IdxBits+1)'(TABLE_ENTRIES);
   localparam logic [IdxBits:0] WrapVal  = (IdxBits+1)'(HistWrap);
   localparam logic [IdxBits:0] WrapComp = (IdxBits+1)'(TABLE_ENTRIES - HistWrap);

   logic [HISTORY_BITS-1:0] history_ff;
   logic [HISTORY_BITS-1:0] history_in;
   logic [IdxBits-1:0]      hidx_ff;
   logic [IdxBits-1:0]      hidx_in;
   logic [IdxBits:0]        dbl;
   logic [IdxBits:0]        folded;
   logic                    accept;
   logic                    push;
   logic                    is_train;

   assign req_ready = enq_ready & ~clear_busy;
   assign accept    = req_valid & req_ready;
   assign is_train  = (req_data.op == OP_TRAIN);

   always_comb begin
      enq_valid = 1'b0;
      push      = 1'b0;
      case (req_data.op)
         OP_PREDICT: enq_valid = accept;
         OP_TRAIN:   enq_valid = accept;
         OP_PUSH:    push      = accept;
         default: ;
      endcase
   end

   always_comb begin
      enq_cmd.is_train      = is_train;
      enq_cmd.outcome_taken = req_data.outcome_taken;
      enq_cmd.history_out   = HIST_OUT_BITS'(history_ff);
      if (is_train) begin
         enq_key = KeyBits'(req_data.saved_history[SnapBits-1:0]);
      end else begin
         enq_key = KeyBits'(hidx_ff);
      end
   end

   // Track history mod table size: double, add the outcome, drop the bit that
   // leaves the history.
   always_comb begin
      dbl = {hidx_ff, req_data.outcome_taken};
      if (dbl >= TabSize) begin
         dbl = dbl - TabSize;
      end
      folded = dbl;
      if (history_ff[HISTORY_BITS-1]) begin
         if (dbl >= WrapVal) begin
            folded = dbl - WrapVal;
         end else begin
            folded = dbl + WrapComp;
         end
      end
   end

   always_comb begin
      history_in = history_ff;
      hidx_in    = hidx_ff;
      if (push) begin
         history_in = HISTORY_BITS'({history_ff, req_data.outcome_taken});
         hidx_in    = folded[IdxBits-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff <= '0;
         hidx_ff    <= '0;
      end else begin
         history_ff <= history_in;
         hidx_ff    <= hidx_in;
      end
   end

endmodule

/* rtl/core/ghbp_cmd_queue.sv */
module ghbp_cmd_queue #(
   parameter int HISTORY_BITS  = ghbp_pkg::HISTORY_BITS_DEF,
   parameter int TABLE_ENTRIES = ghbp_pkg::TABLE_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enq_valid,
   output logic              enq_ready,
   input  ghbp_pkg::cmd_type enq_cmd,
   input  logic [ghbp_pkg::ghbp_key_bits(HISTORY_BITS, TABLE_ENTRIES)-1:0] enq_key,
   output logic              deq_valid,
   input  logic              deq_ready,
   output ghbp_pkg::cmd_type deq_cmd,
   output logic [ghbp_pkg::ghbp_key_bits(HISTORY_BITS, TABLE_ENTRIES)-1:0] deq_key
);
   import ghbp_pkg::*;

   localparam int KeyBits = ghbp_key_bits(HISTORY_BITS, TABLE_ENTRIES);
   localparam int PtrBits = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntBits = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrBits-1:0] LastPtr = PtrBits'(QUEUE_DEPTH - 1);
   localparam logic [CntBits-1:0] FullCnt = CntBits'(QUEUE_DEPTH);

   cmd_type              cmd_q [QUEUE_DEPTH];
   logic [KeyBits-1:0]   key_q [QUEUE_DEPTH];
   logic [PtrBits-1:0]   wr_ptr_ff;
   logic [PtrBits-1:0]   wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff;
   logic [PtrBits-1:0]   rd_ptr_in;
   logic [CntBits-1:0]   count_ff;
   logic [CntBits-1:0]   count_in;
   logic                 do_enq;
   logic                 do_deq;

   assign enq_ready = (count_ff != FullCnt);
   assign deq_valid = (count_ff != '0);
   assign do_enq    = enq_valid & enq_ready;
   assign do_deq    = deq_valid & deq_ready;
   assign deq_cmd   = cmd_q[rd_ptr_ff];
   assign deq_key   = key_q[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_enq) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_deq) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_enq && !do_deq) begin
         count_in = count_ff + 1'b1;
      end else if (do_deq && !do_enq) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_enq) begin
         cmd_q[wr_ptr_ff] <= enq_cmd;
         key_q[wr_ptr_ff] <= enq_key;
      end
   end

endmodule

/* rtl/core/ghbp_back.sv */
module ghbp_back #(
   parameter int HISTORY_BITS  = ghbp_pkg::HISTORY_BITS_DEF,
   parameter int TABLE_ENTRIES = ghbp_pkg::TABLE_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              deq_valid,
   output logic              deq_ready,
   input  ghbp_pkg::cmd_type deq_cmd,
   input  logic [ghbp_pkg::ghbp_key_bits(HISTORY_BITS, TABLE_ENTRIES)-1:0] deq_key,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ghbp_pkg::rsp_type rsp_data,
   output logic              clear_busy
);
   import ghbp_pkg::*;

   localparam int IdxBits   = ghbp_idx_bits(TABLE_ENTRIES);
   localparam int SnapBits  = ghbp_snap_bits(HISTORY_BITS);
   localparam bit Fast      = ghbp_fast(HISTORY_BITS, TABLE_ENTRIES);
   localparam int RedCycles = (SnapBits + REDUCE_STEP - 1) / REDUCE_STEP;
   localparam int PadBits   = RedCycles * REDUCE_STEP;
   localparam int CntBits   = $clog2(RedCycles + 1);
   localparam logic [CntBits-1:0] RedLoad = CntBits'(RedCycles);
   localparam logic [IdxBits:0]   TabSize = (IdxBits+1)'(TABLE_ENTRIES);
   localparam logic [IdxBits-1:0] LastIdx = IdxBits'(TABLE_ENTRIES - 1);

   back_state_type     state_ff;
   back_state_type     state_in;
   logic               clearing;
   logic [IdxBits-1:0] clr_idx_ff;
   logic [IdxBits-1:0] clr_idx_in;

   logic [1:0]         ctr_mem [TABLE_ENTRIES];
   logic [1:0]         rd_data_ff;
   logic               fwd_hit_ff;
   logic [1:0]         fwd_data_ff;

   logic               s1_valid_ff;
   logic               s1_valid_in;
   cmd_type            s1_cmd_ff;
   logic [IdxBits-1:0] s1_idx_ff;
   logic [IdxBits-1:0] s1_idx_in;
   logic [PadBits-1:0] s1_bits_ff;
   logic [PadBits-1:0] s1_bits_in;
   logic [CntBits-1:0] s1_cnt_ff;
   logic [CntBits-1:0] s1_cnt_in;

   logic               s2_valid_ff;
   logic               s2_valid_in;
   cmd_type            s2_cmd_ff;
   logic [IdxBits-1:0] s2_idx_ff;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_data_ff;

   logic               load;
   logic               slow_train;
   logic               s1_move;
   logic               s2_done;
   logic               s2_open;
   logic               rsp_free;
   logic               rd_en;
   logic               wr_en;
   logic [IdxBits-1:0] wr_idx;
   logic [1:0]         wr_data;
   logic [1:0]         ctr_cur;
   logic [1:0]         ctr_next;
   logic [IdxBits-1:0] red_rem;
   logic [PadBits-1:0] red_bits;
   logic [IdxBits:0]   red_wide;

   // Clearing pass sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_CLEAR: begin
            if (clr_idx_ff == LastIdx) begin
               state_in = BK_RUN;
            end
         end
         BK_RUN: state_in = BK_RUN;
         default: state_in = BK_CLEAR;
      endcase
   end

   always_comb begin
      case (state_ff)
         BK_CLEAR: clearing = 1'b1;
         BK_RUN:   clearing = 1'b0;
         default:  clearing = 1'b1;
      endcase
   end

   assign clr_idx_in = clearing ? clr_idx_ff + 1'b1 : clr_idx_ff;
   assign clear_busy = clearing;

   // Handshake between stages.
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign s2_done    = s2_valid_ff && (s2_cmd_ff.is_train || rsp_free);
   assign s2_open    = !s2_valid_ff || s2_done;
   assign s1_move    = s1_valid_ff && (s1_cnt_ff == '0) && s2_open;
   assign deq_ready  = !s1_valid_ff || s1_move;
   assign load       = deq_valid && deq_ready;
   assign slow_train = deq_cmd.is_train && !Fast;
   assign rd_en      = s1_move;

   // Fold snapshot bits into the index, MSB first.
   always_comb begin
      red_rem  = s1_idx_ff;
      red_bits = s1_bits_ff;
      red_wide = '0;
      for (int j = 0; j < REDUCE_STEP; j++) begin
         red_wide = {red_rem, red_bits[PadBits-1]};
         if (red_wide >= TabSize) begin
            red_wide = red_wide - TabSize;
         end
         red_rem  = red_wide[IdxBits-1:0];
         red_bits = red_bits << 1;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_cnt_in   = s1_cnt_ff;
      s1_idx_in   = s1_idx_ff;
      s1_bits_in  = s1_bits_ff;
      if (load) begin
         s1_valid_in = 1'b1;
         s1_cnt_in   = slow_train ? RedLoad : '0;
         s1_idx_in   = slow_train ? '0 : deq_key[IdxBits-1:0];
         s1_bits_in  = PadBits'(deq_key);
      end else begin
         if (s1_move) begin
            s1_valid_in = 1'b0;
         end
         if (s1_cnt_ff != '0) begin
            s1_cnt_in  = s1_cnt_ff - 1'b1;
            s1_idx_in  = red_rem;
            s1_bits_in = red_bits;
         end
      end
   end

   assign s2_valid_in = s1_move ? 1'b1 : (s2_done ? 1'b0 : s2_valid_ff);

   // A write in the same cycle as the read is not seen by the memory; forward it.
   assign ctr_cur = fwd_hit_ff ? fwd_data_ff : rd_data_ff;

   always_comb begin
      if (s2_cmd_ff.outcome_taken) begin
         ctr_next = (ctr_cur == CTR_MAX) ? CTR_MAX : ctr_cur + 2'd1;
      end else begin
         ctr_next = (ctr_cur == CTR_MIN) ? CTR_MIN : ctr_cur - 2'd1;
      end
   end

   assign wr_en   = clearing || (s2_done && s2_cmd_ff.is_train);
   assign wr_idx  = clearing ? clr_idx_ff : s2_idx_ff;
   assign wr_data = clearing ? CTR_MIN : ctr_next;

   assign rsp_valid_in = (s2_done && !s2_cmd_ff.is_train) ? 1'b1 :
                         (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_idx_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         s1_cnt_ff    <= '0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         s1_valid_ff  <= s1_valid_in;
         s1_cnt_ff    <= s1_cnt_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff  <= s1_idx_in;
      s1_bits_ff <= s1_bits_in;
      if (load) begin
         s1_cmd_ff <= deq_cmd;
      end
      if (s1_move) begin
         s2_cmd_ff <= s1_cmd_ff;
         s2_idx_ff <= s1_idx_ff;
      end
      if (s2_done && !s2_cmd_ff.is_train) begin
         rsp_data_ff.predict_taken <= (ctr_cur >= CTR_TAKEN_MIN);
         rsp_data_ff.history_out   <= s2_cmd_ff.history_out;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ctr_mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= ctr_mem[s1_idx_ff];
         fwd_hit_ff  <= wr_en && (wr_idx == s1_idx_ff);
         fwd_data_ff <= wr_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      clearing |-> (!s1_valid_ff && !s2_valid_ff))
      else $error("item in back stages during clearing pass");

   a_no_read_on_stall: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !s2_done) |-> !rd_en)
      else $error("counter read while result stage is stalled");

   a_reduce_train: assert property (@(posedge clock) disable iff (reset)
      (s1_cnt_ff != '0) |-> (s1_valid_ff && s1_cmd_ff.is_train))
      else $error("index reduction running without a train");

   a_rsp_from_predict: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s2_valid_ff && !s2_cmd_ff.is_train))
      else $error("response raised without a predict");

endmodule

/* rtl/core/global_history_branch_predictor.sv */
// GAg branch predictor: a global history register and one table of 2-bit
// saturating counters indexed by history mod TABLE_ENTRIES. A predict request
// returns taken (counter >= 2) and the history snapshot it used; a push request
// shifts an outcome into the history; a train request steps the counter chosen
// by the returned snapshot toward the outcome. Only predicts produce a response.
// After reset the counter memory is cleared one entry per cycle, so req_ready
// stays low until every entry is cleared. Afterwards one request is taken per
// cycle while the command queue has room; a push completes at acceptance, and a
// predict response passes through the command queue, the index stage, the
// counter read stage and the response register. The counter memory has one read
// and one write port: each predict or train reads it once, and a write in the
// same cycle to the entry being read is forwarded. When TABLE_ENTRIES is not a
// power of two and is below the snapshot range, a train first folds the snapshot
// into an index in the index stage, which holds off later requests in the queue.
module global_history_branch_predictor #(
   parameter int HISTORY_BITS  = ghbp_pkg::HISTORY_BITS_DEF,
   parameter int TABLE_ENTRIES = ghbp_pkg::TABLE_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ghbp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ghbp_pkg::rsp_type rsp_data
);
   import ghbp_pkg::*;

   localparam int KeyBits = ghbp_key_bits(HISTORY_BITS, TABLE_ENTRIES);

   logic               clear_busy;
   logic               enq_valid;
   logic               enq_ready;
   cmd_type            enq_cmd;
   logic [KeyBits-1:0] enq_key;
   logic               deq_valid;
   logic               deq_ready;
   cmd_type            deq_cmd;
   logic [KeyBits-1:0] deq_key;

   ghbp_front #(
      .HISTORY_BITS  (HISTORY_BITS),
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .clear_busy (clear_busy),
      .enq_valid  (enq_valid),
      .enq_ready  (enq_ready),
      .enq_cmd    (enq_cmd),
      .enq_key    (enq_key)
   );

   ghbp_cmd_queue #(
      .HISTORY_BITS  (HISTORY_BITS),
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .enq_valid (enq_valid),
      .enq_ready (enq_ready),
      .enq_cmd   (enq_cmd),
      .enq_key   (enq_key),
      .deq_valid (deq_valid),
      .deq_ready (deq_ready),
      .deq_cmd   (deq_cmd),
      .deq_key   (deq_key)
   );

   ghbp_back #(
      .HISTORY_BITS  (HISTORY_BITS),
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .deq_valid  (deq_valid),
      .deq_ready  (deq_ready),
      .deq_cmd    (deq_cmd),
      .deq_key    (deq_key),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .clear_busy (clear_busy)
   );

endmodule
